// ===== hdl/sso_pkg.sv =====
package sso_pkg;

    // sizes of the sine table and the output word (table depth is a power of two)
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int OUT_BITS         = 16;

    // field widths
    localparam int SR_W   = 18;
    localparam int FREQ_W = 23;
    localparam int PW_W   = 16;
    localparam int FRAC_W = 16;
    localparam int DVD_W  = SR_W + FRAC_W;
    localparam int LEN_W  = DVD_W;
    localparam int HALF_W = LEN_W - 1;
    localparam int POS_W  = 36;

    // angle arithmetic
    localparam int TAB_AW = $clog2(SINE_TABLE_DEPTH);
    localparam int ANG_W  = $clog2(4 * SINE_TABLE_DEPTH);
    localparam int AD_W   = POS_W + $clog2(2 * SINE_TABLE_DEPTH);

    // one sample step in position units, and the register reset
    localparam int POS_ONE  = 256;
    localparam int SR_RESET = 44100;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [OUT_BITS-2:0] FULL_SCALE = {(OUT_BITS-1){1'b1}};
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // segment lengths for one tick
    typedef struct packed {
        logic [HALF_W-1:0] half;
        logic [LEN_W-1:0]  hi_len;
        logic [LEN_W-1:0]  lo_len;
    } seg_t;

    typedef logic [OUT_BITS-2:0] sine_tab_t [0:SINE_TABLE_DEPTH];

    // shift and subtract division for the table build
    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // quarter-wave table, taylor series in q30, rounded to full scale
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t       tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (HALF_PI_Q30 * longint'(i)) >> TAB_AW;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 8; k++) begin
                term = (term * x2) >> 30;
                term = div_u64(term, 64'((2 * k) * (2 * k + 1)));
                if ((k & 1) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum * longint'(FULL_SCALE) + (longint'(1) <<< 29)) >>> 30;
            if (v > longint'(FULL_SCALE)) begin
                v = longint'(FULL_SCALE);
            end
            tab[i] = (OUT_BITS-1)'(v);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ===== hdl/sso_front.sv =====
module sso_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sso_pkg::SR_W-1:0]      cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sso_pkg::FREQ_W-1:0]    s_tone_freq,
    input  logic [sso_pkg::FREQ_W-1:0]    s_edge_freq,
    input  logic [sso_pkg::PW_W-1:0]      s_pulse_width,
    output logic                          q_valid,
    input  logic                          q_ready,
    output sso_pkg::seg_t                 q_data
);

    typedef enum logic [2:0] {F_IDLE, F_DIV, F_LEN, F_MUL, F_PUSH} fstate_t;

    localparam int CNT_W = $clog2(sso_pkg::DVD_W);

    fstate_t                           state_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [sso_pkg::SR_W-1:0]          sr_reg;
    logic [sso_pkg::FREQ_W-1:0]        tdiv_reg;
    logic [sso_pkg::FREQ_W-1:0]        ediv_reg;
    logic [sso_pkg::PW_W-1:0]          pw_reg;
    logic [sso_pkg::DVD_W-1:0]         dq_a_reg;
    logic [sso_pkg::DVD_W-1:0]         dq_b_reg;
    logic [sso_pkg::FREQ_W-1:0]        rem_a_reg;
    logic [sso_pkg::FREQ_W-1:0]        rem_b_reg;
    logic [sso_pkg::LEN_W-1:0]         diff_reg;
    logic [sso_pkg::HALF_W-1:0]        half_reg;
    logic [sso_pkg::LEN_W+sso_pkg::PW_W-1:0] prod_reg;

    logic [sso_pkg::FREQ_W:0]          rem_sh_a;
    logic [sso_pkg::FREQ_W:0]          rem_sh_b;
    logic                              ge_a;
    logic                              ge_b;
    logic [sso_pkg::FREQ_W-1:0]        rem_a_next;
    logic [sso_pkg::FREQ_W-1:0]        rem_b_next;
    logic [sso_pkg::DVD_W-1:0]         dq_a_next;
    logic [sso_pkg::DVD_W-1:0]         dq_b_next;
    logic [sso_pkg::LEN_W-1:0]         slen_c;
    logic [sso_pkg::LEN_W-1:0]         hi_c;
    logic                              frac_c;

    // one restoring step for the period and the edge length
    always_comb begin
        rem_sh_a   = {rem_a_reg, dq_a_reg[sso_pkg::DVD_W-1]};
        rem_sh_b   = {rem_b_reg, dq_b_reg[sso_pkg::DVD_W-1]};
        ge_a       = rem_sh_a >= {1'b0, tdiv_reg};
        ge_b       = rem_sh_b >= {1'b0, ediv_reg};
        rem_a_next = ge_a ? sso_pkg::FREQ_W'(rem_sh_a - {1'b0, tdiv_reg})
                          : rem_sh_a[sso_pkg::FREQ_W-1:0];
        rem_b_next = ge_b ? sso_pkg::FREQ_W'(rem_sh_b - {1'b0, ediv_reg})
                          : rem_sh_b[sso_pkg::FREQ_W-1:0];
        dq_a_next  = {dq_a_reg[sso_pkg::DVD_W-2:0], ge_a};
        dq_b_next  = {dq_b_reg[sso_pkg::DVD_W-2:0], ge_b};
    end

    // edge length capped at the period
    assign slen_c = (dq_b_reg > dq_a_reg) ? dq_a_reg : dq_b_reg;

    // hold lengths, low hold from the same product
    assign hi_c   = prod_reg[sso_pkg::LEN_W+sso_pkg::PW_W-1:sso_pkg::PW_W];
    assign frac_c = prod_reg[sso_pkg::PW_W-1:0] != '0;

    assign s_ready        = state_reg == F_IDLE;
    assign q_valid        = state_reg == F_PUSH;
    assign q_data.half    = half_reg;
    assign q_data.hi_len  = hi_c;
    assign q_data.lo_len  = diff_reg - hi_c - sso_pkg::LEN_W'(frac_c);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            sr_reg    <= sso_pkg::SR_W'(sso_pkg::SR_RESET);
            cnt_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                sr_reg <= cfg_wr_data;
            end
            case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        tdiv_reg  <= (s_tone_freq == '0) ? sso_pkg::FREQ_W'(1) : s_tone_freq;
                        ediv_reg  <= (s_edge_freq == '0) ? sso_pkg::FREQ_W'(1) : s_edge_freq;
                        pw_reg    <= s_pulse_width;
                        dq_a_reg  <= {sr_reg, {sso_pkg::FRAC_W{1'b0}}};
                        dq_b_reg  <= {sr_reg, {sso_pkg::FRAC_W{1'b0}}};
                        rem_a_reg <= '0;
                        rem_b_reg <= '0;
                        cnt_reg   <= '0;
                        state_reg <= F_DIV;
                    end
                end
                F_DIV: begin
                    dq_a_reg  <= dq_a_next;
                    dq_b_reg  <= dq_b_next;
                    rem_a_reg <= rem_a_next;
                    rem_b_reg <= rem_b_next;
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(sso_pkg::DVD_W - 1)) begin
                        state_reg <= F_LEN;
                    end
                end
                F_LEN: begin
                    half_reg  <= slen_c[sso_pkg::LEN_W-1:1];
                    diff_reg  <= dq_a_reg - slen_c;
                    state_reg <= F_MUL;
                end
                F_MUL: begin
                    prod_reg  <= diff_reg * pw_reg;
                    state_reg <= F_PUSH;
                end
                F_PUSH: begin
                    if (q_ready) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/sso_fifo.sv =====
module sso_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  sso_pkg::seg_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output sso_pkg::seg_t  out_data
);

    sso_pkg::seg_t                 mem_reg [0:sso_pkg::QUEUE_DEPTH-1];
    logic [sso_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [sso_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [sso_pkg::QPTR_W:0]      count_reg;
    logic                          push;
    logic                          pop;

    assign in_ready  = count_reg != (sso_pkg::QPTR_W+1)'(sso_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/sso_back.sv =====
module sso_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  sso_pkg::seg_t                  q_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [sso_pkg::OUT_BITS-1:0] m_sample
);

    typedef enum logic [1:0] {B_IDLE, B_DIV, B_FIN} bstate_t;

    localparam int CNT_W = $clog2(sso_pkg::AD_W);
    localparam int N     = sso_pkg::SINE_TABLE_DEPTH;

    bstate_t                             state_reg;
    logic [CNT_W-1:0]                    cnt_reg;
    logic [sso_pkg::POS_W-1:0]           pos_reg;
    logic [1:0]                          phase_reg;
    sso_pkg::seg_t                       seg_reg;
    logic [sso_pkg::AD_W-1:0]            dq_reg;
    logic [sso_pkg::HALF_W-1:0]          rem_reg;
    logic [sso_pkg::ANG_W-1:0]           ang_reg;
    logic                                m_valid_reg;
    logic signed [sso_pkg::OUT_BITS-1:0] m_sample_reg;

    logic [sso_pkg::HALF_W:0]            rem_sh;
    logic                                ge;
    logic [sso_pkg::HALF_W-1:0]          rem_next;
    logic [sso_pkg::AD_W-1:0]            dq_next;
    logic [sso_pkg::ANG_W-1:0]           ang_c;
    logic [sso_pkg::TAB_AW:0]            idx_c;
    logic [sso_pkg::OUT_BITS-2:0]        mag_c;
    logic                                neg_c;
    logic signed [sso_pkg::OUT_BITS-1:0] sample_c;
    logic [sso_pkg::POS_W:0]             sum_c;
    logic [sso_pkg::LEN_W-1:0]           hold_c;
    logic [sso_pkg::POS_W-1:0]           pos_next;
    logic [1:0]                          phase_next;
    logic                                out_free;
    logic                                fire;

    // one restoring step of position * 2N / half
    always_comb begin
        rem_sh   = {rem_reg, dq_reg[sso_pkg::AD_W-1]};
        ge       = rem_sh >= {1'b0, seg_reg.half};
        rem_next = ge ? sso_pkg::HALF_W'(rem_sh - {1'b0, seg_reg.half})
                      : rem_sh[sso_pkg::HALF_W-1:0];
        dq_next  = {dq_reg[sso_pkg::AD_W-2:0], ge};
    end

    // sine lookup: rising edge starts at three quarters, falling at one quarter
    always_comb begin
        ang_c = ang_reg + (phase_reg[1] ? sso_pkg::ANG_W'(N) : sso_pkg::ANG_W'(3 * N));
        if (ang_c[sso_pkg::ANG_W-2]) begin
            idx_c = (sso_pkg::TAB_AW+1)'(N) - {1'b0, ang_c[sso_pkg::TAB_AW-1:0]};
        end else begin
            idx_c = {1'b0, ang_c[sso_pkg::TAB_AW-1:0]};
        end
        if (phase_reg[0]) begin
            mag_c = sso_pkg::FULL_SCALE;
            neg_c = phase_reg[1];
        end else begin
            mag_c = sso_pkg::SINE_TAB[idx_c];
            neg_c = ang_c[sso_pkg::ANG_W-1];
        end
        sample_c = neg_c ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    end

    // position and phase after this tick
    always_comb begin
        sum_c      = {1'b0, pos_reg} + (sso_pkg::POS_W+1)'(sso_pkg::POS_ONE);
        hold_c     = phase_reg[1] ? seg_reg.lo_len : seg_reg.hi_len;
        pos_next   = sum_c[sso_pkg::POS_W-1:0];
        phase_next = phase_reg;
        if (!phase_reg[0]) begin
            if (sum_c >= (sso_pkg::POS_W+1)'(seg_reg.half)) begin
                pos_next   = sso_pkg::POS_W'(sum_c - (sso_pkg::POS_W+1)'(seg_reg.half));
                phase_next = phase_reg + 2'd1;
            end
        end else begin
            if (pos_reg > sso_pkg::POS_W'(hold_c)) begin
                pos_next   = sso_pkg::POS_W'(sum_c - (sso_pkg::POS_W+1)'(hold_c));
                phase_next = phase_reg + 2'd1;
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = (state_reg == B_FIN) && out_free;
    assign q_ready  = state_reg == B_IDLE;
    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            pos_reg     <= '0;
            phase_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (q_valid) begin
                        seg_reg <= q_data;
                        ang_reg <= '0;
                        if (!phase_reg[0] && q_data.half != '0) begin
                            dq_reg    <= sso_pkg::AD_W'(pos_reg * (2 * N));
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= B_DIV;
                        end else begin
                            state_reg <= B_FIN;
                        end
                    end
                end
                B_DIV: begin
                    dq_reg  <= dq_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(sso_pkg::AD_W - 1)) begin
                        ang_reg   <= dq_next[sso_pkg::ANG_W-1:0];
                        state_reg <= B_FIN;
                    end
                end
                B_FIN: begin
                    if (out_free) begin
                        m_sample_reg <= sample_c;
                        pos_reg      <= pos_next;
                        phase_reg    <= phase_next;
                        state_reg    <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/soft_square_oscillator_unit.sv =====
// channel   direction  transfer when        payload
// s_        in         s_valid && s_ready   s_tone_freq, s_edge_freq, s_pulse_width
// m_        out        m_valid && m_ready   m_sample
// cfg_      in         cfg_wr_en            cfg_wr_data (sample rate)
//
// the front divides the sample rate by both frequencies, one bit a cycle; a two-entry queue
// carries the segment lengths to the back
// the back walks the phase machine; in an edge phase the angle divider takes one bit a
// cycle, in a hold phase no division runs; in an edge phase the back sets the rate
// aresetn (synchronous) clears position, phase, queue and the sample rate to 44100
// a stalled output holds the back only; the front keeps working until the queue is full
module soft_square_oscillator_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [sso_pkg::SR_W-1:0]             cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [sso_pkg::FREQ_W-1:0]           s_tone_freq,
    input  logic [sso_pkg::FREQ_W-1:0]           s_edge_freq,
    input  logic [sso_pkg::PW_W-1:0]             s_pulse_width,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [sso_pkg::OUT_BITS-1:0]  m_sample
);

    logic          fq_valid;
    logic          fq_ready;
    sso_pkg::seg_t fq_data;
    logic          qb_valid;
    logic          qb_ready;
    sso_pkg::seg_t qb_data;

    // segment lengths per tick
    sso_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_tone_freq   (s_tone_freq),
        .s_edge_freq   (s_edge_freq),
        .s_pulse_width (s_pulse_width),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_data        (fq_data)
    );

    // queue between front and back
    sso_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    // phase machine and sample output
    sso_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_data   (qb_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_sample (m_sample)
    );

endmodule

// ===== tb/soft_square_oscillator_unit_tb.sv =====
`timescale 1ns / 100ps

module soft_square_oscillator_unit_tb;

    localparam int N_DEPTH   = sso_pkg::SINE_TABLE_DEPTH;
    localparam int OUT_BITS  = sso_pkg::OUT_BITS;
    localparam int SR_W      = sso_pkg::SR_W;
    localparam int FREQ_W    = sso_pkg::FREQ_W;
    localparam int PW_W      = sso_pkg::PW_W;
    localparam int SR_RESET  = sso_pkg::SR_RESET;
    localparam int N_RANDOM  = 1800;
    localparam int FS        = (1 << (OUT_BITS - 1)) - 1;
    localparam int SR_MIN    = 8000;
    localparam int SR_MAX    = 192000;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [SR_W-1:0]               cfg_wr_data;
    logic                          s_valid;
    logic                          s_ready;
    logic [FREQ_W-1:0]             s_tone_freq;
    logic [FREQ_W-1:0]             s_edge_freq;
    logic [PW_W-1:0]               s_pulse_width;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [OUT_BITS-1:0]    m_sample;

    soft_square_oscillator_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_tone_freq   (s_tone_freq),
        .s_edge_freq   (s_edge_freq),
        .s_pulse_width (s_pulse_width),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample      (m_sample)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // oscillator model state
    longint unsigned      osc_rate;
    longint unsigned      osc_pos;
    int unsigned          osc_phase;
    int                   quarter_wave [0:N_DEPTH];
    logic [OUT_BITS-1:0]  sample_queue [$];
    int                   fail_count;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    bit                   recv_hold;
    bit                   stim_done;

    // quarter-wave table, taylor series in q30
    function automatic void fill_quarter_wave();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        for (int i = 0; i <= N_DEPTH; i++) begin
            x    = (64'd1686629713 * longint'(i)) / N_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 8; k++) begin
                term = (term * x2) >> 30;
                term = term / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            v = (sum * FS + (longint'(1) << 29)) >>> 30;
            if (v > FS) v = FS;
            quarter_wave[i] = int'(v);
        end
    endfunction

    function automatic int sine_of(longint unsigned angle);
        longint unsigned a;
        longint unsigned q;
        longint unsigned r;
        a = angle % (4 * N_DEPTH);
        q = a / N_DEPTH;
        r = a % N_DEPTH;
        case (q)
            0: return quarter_wave[r];
            1: return quarter_wave[N_DEPTH - r];
            2: return -quarter_wave[r];
            default: return -quarter_wave[N_DEPTH - r];
        endcase
    endfunction

    // one oscillator tick: returns the sample and advances position and phase
    function automatic logic [OUT_BITS-1:0] next_sample(longint unsigned tf,
            longint unsigned ef, longint unsigned pw);
        longint unsigned period;
        longint unsigned slen;
        longint unsigned half;
        longint unsigned diff;
        longint unsigned hi_len;
        longint unsigned lo_len;
        longint unsigned ang;
        int              s;
        if (tf == 0) tf = 1;
        if (ef == 0) ef = 1;
        period = (osc_rate << 16) / tf;
        slen   = (osc_rate << 16) / ef;
        if (slen > period) slen = period;
        half   = slen >> 1;
        diff   = period - slen;
        hi_len = (diff * pw) >> 16;
        lo_len = (diff * (65536 - pw)) >> 16;
        ang    = (half == 0) ? 0 : (osc_pos * (2 * N_DEPTH)) / half;
        case (osc_phase)
            0, 2: begin
                s = sine_of(ang + ((osc_phase == 0) ? 3 * N_DEPTH : N_DEPTH));
                osc_pos += 256;
                if (osc_pos >= half) begin
                    osc_pos -= half;
                    osc_phase = osc_phase + 1;
                end
            end
            1: begin
                s = FS;
                if (osc_pos > hi_len) begin
                    osc_pos = osc_pos + 256 - hi_len;
                    osc_phase = 2;
                end else osc_pos += 256;
            end
            default: begin
                s = -FS;
                if (osc_pos > lo_len) begin
                    osc_pos = osc_pos + 256 - lo_len;
                    osc_phase = 0;
                end else osc_pos += 256;
            end
        endcase
        osc_pos &= (64'd1 << 36) - 1;
        return s[OUT_BITS-1:0];
    endfunction

    // directed rows: tone, edge, width, typed sample or none
    typedef struct {
        logic [FREQ_W-1:0] tone;
        logic [FREQ_W-1:0] edge_f;
        logic [PW_W-1:0]   width;
        bit                typed;
        int                want;
    } tick_row_t;

    tick_row_t directed_rows [] = '{
        '{23'd112640, 23'd1126400, 16'd32768, 1'b1, -FS},  // first tick after reset
        '{23'd112640, 23'd1126400, 16'd32768, 1'b0, 0},
        '{23'd112640, 23'd1126400, 16'd32768, 1'b0, 0},
        '{23'd0,      23'd0,       16'd0,     1'b0, 0},    // zero frequencies
        '{23'd0,      23'd0,       16'd65535, 1'b0, 0},
        '{23'h7fffff, 23'h7fffff,  16'd0,     1'b0, 0},    // all-ones frequencies
        '{23'h7fffff, 23'h7fffff,  16'd65535, 1'b0, 0},
        '{23'h7fffff, 23'd0,       16'd65535, 1'b0, 0},
        '{23'd5120000, 23'd5120000, 16'd0,    1'b0, 0},
        '{23'd256,    23'd5120000, 16'd65535, 1'b0, 0},
        '{23'd256,    23'd5120000, 16'd65535, 1'b0, 0},
        '{23'd256,    23'd5120000, 16'd0,     1'b0, 0},
        '{23'd256,    23'd5120000, 16'd0,     1'b0, 0},
        '{23'd5120000, 23'd256,    16'd32768, 1'b0, 0},    // edge capped at period
        '{23'd5120000, 23'd256,    16'd32768, 1'b0, 0},
        '{23'd25600,  23'd512000,  16'd1,     1'b0, 0},
        '{23'd25600,  23'd512000,  16'd1,     1'b0, 0},
        '{23'd1,      23'd1,       16'd65535, 1'b0, 0}
    };
    bit   typed_queue [$];
    int   typed_want  [$];

    // one input transfer, driven at the falling edge; valid drops only while idling
    task automatic send_tick(logic [FREQ_W-1:0] tf, logic [FREQ_W-1:0] ef,
            logic [PW_W-1:0] pw, bit typed, int want);
        if ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99, 0) < send_idle_pct) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_tone_freq   <= tf;
        s_edge_freq   <= ef;
        s_pulse_width <= pw;
        sample_queue.push_back(next_sample(tf, ef, pw));
        typed_queue.push_back(typed);
        typed_want.push_back(want);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // let the block drain before a register write
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sample_queue.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_rate(logic [SR_W-1:0] rate);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rate;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        osc_rate = rate;
    endtask

    // random tick: mostly audio-range values, sometimes extreme bits
    task automatic send_random();
        logic [FREQ_W-1:0] tf;
        logic [FREQ_W-1:0] ef;
        logic [PW_W-1:0]   pw;
        case ($urandom_range(9, 0))
            0: begin
                tf = FREQ_W'($urandom);
                ef = FREQ_W'($urandom);
            end
            1, 2, 3: begin
                tf = FREQ_W'($urandom_range(5120000, 0));
                ef = FREQ_W'($urandom_range(5120000, 0));
            end
            default: begin
                tf = FREQ_W'($urandom_range(256 * 4000, 256 * 400));
                ef = FREQ_W'($urandom_range(256 * 20000, 256 * 2000));
            end
        endcase
        pw = PW_W'($urandom);
        send_tick(tf, ef, pw, 1'b0, 0);
    endtask

    // stimulus
    initial begin
        int phase_len;
        fill_quarter_wave();
        osc_rate      = SR_RESET;
        osc_pos       = 0;
        osc_phase     = 0;
        fail_count    = 0;
        stim_done     = 1'b0;
        send_idle_pct = 8;
        recv_idle_pct = 57;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_tone_freq   = '0;
        s_edge_freq   = '0;
        s_pulse_width = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_tick(directed_rows[i].tone, directed_rows[i].edge_f,
                directed_rows[i].width, directed_rows[i].typed, directed_rows[i].want);

        // rate sweep, extremes first; idling pattern changes per third
        phase_len = N_RANDOM / 6;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: write_rate(SR_W'(SR_MIN));
                1: write_rate(SR_W'(SR_MAX));
                2: write_rate(SR_W'(0));
                3: write_rate(18'h3ffff);
                4: write_rate(SR_W'(48000));
                default: write_rate(SR_W'($urandom_range(SR_MAX, SR_MIN)));
            endcase
            if (p == 2) begin
                send_idle_pct = 57;
                recv_idle_pct = 8;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 1) recv_hold = 1'b1;
            for (int i = 0; i < phase_len; i++) send_random();
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver readiness, with one long hold-off while the sender keeps going
    initial begin
        recv_hold = 1'b0;
        m_ready   = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (recv_hold) begin
                m_ready <= 1'b0;
                repeat (600) @(negedge aclk);
                recv_hold = 1'b0;
            end
            m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // output check at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (sample_queue.size() == 0) begin
                $error("sample: unexpected transfer, actual %0d", m_sample);
                fail_count++;
            end else begin
                if (m_sample !== sample_queue[0]) begin
                    $error("sample: expected %0d actual %0d",
                        $signed(sample_queue[0]), m_sample);
                    fail_count++;
                end
                if (typed_queue[0] && m_sample !== typed_want[0][OUT_BITS-1:0]) begin
                    $error("sample: expected %0d actual %0d", typed_want[0], m_sample);
                    fail_count++;
                end
                void'(sample_queue.pop_front());
                void'(typed_queue.pop_front());
                void'(typed_want.pop_front());
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        wait (sample_queue.size() == 0);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) $display("[soft_square_oscillator_unit] OK");
        else $display("[soft_square_oscillator_unit] ERROR");
        $finish;
    end

    // timeout
    initial begin
        #20ms;
        $display("[soft_square_oscillator_unit] ERROR");
        $finish;
    end

endmodule
